// ----- rtl/core/lll_pkg.sv -----
package lll_pkg;

   localparam int N_FEATURES = 4;
   localparam int FEAT_W     = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int ACC_W      = 48;
   localparam int CNT_W      = 32;
   localparam int FI_W       = $clog2(N_FEATURES);
   localparam int PAIR_W     = 2 * FEAT_W;
   localparam int DOT_W      = PAIR_W + $clog2(N_FEATURES);
   localparam int XB_SHIFT   = 8;
   localparam int XB_W       = DOT_W - XB_SHIFT;
   localparam int MUL_W      = 22;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SP_W       = 20;
   localparam int FRAC_W     = 20;
   localparam int XB_LIMIT   = 524288;

   localparam int COEF_BASE = 0;

   localparam logic signed [XB_W-1:0]  XB_HI   = XB_W'(XB_LIMIT);
   localparam logic signed [XB_W-1:0]  XB_LO   = -XB_HI;
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_DOT,
      S_RANGE,
      S_POS,
      S_RD0,
      S_RD1,
      S_RD2,
      S_INTERP,
      S_TERM,
      S_DONE
   } state_type;

   // shift-subtract divide, elaboration only
   function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      int          i;
      quo = '0;
      rem = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // softplus at table point k: max(x,0) + ln(1+e^-|x|), unsigned Q4.16
   function automatic logic [SP_W-1:0] sp_point(int k, int entries);
      logic [63:0] xq;
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] y;
      logic [63:0] z;
      logic [63:0] w;
      logic [63:0] p;
      logic [63:0] s_ln;
      logic [63:0] l;
      longint      x;
      longint      base;
      longint      s_ex;
      int          j;
      xq   = udiv(64'(k) << 20, 64'(entries));
      x    = longint'(xq) - longint'(XB_LIMIT);
      a    = (x < 0) ? 64'(-x) : 64'(x);
      base = (x > 0) ? x : 0;
      r    = a << 11;
      t    = 64'd1 << 31;
      s_ex = longint'(64'd1 << 31);
      for (j = 1; j <= 20; j++) begin
         t = udiv((t * r) >> 31, 64'(j));
         if (j[0]) begin
            s_ex = s_ex - longint'(t);
         end else begin
            s_ex = s_ex + longint'(t);
         end
      end
      y = (s_ex > 0) ? 64'(s_ex) : 64'd0;
      for (j = 0; j < 4; j++) begin
         y = (y * y + (64'd1 << 30)) >> 31;
      end
      z    = udiv(y << 31, (64'd1 << 32) + y);
      w    = (z * z) >> 31;
      p    = z;
      s_ln = '0;
      for (j = 0; j < 16; j++) begin
         s_ln = s_ln + udiv(p, 64'(2 * j + 1));
         p    = (p * w) >> 31;
      end
      l = s_ln << 1;
      return SP_W'(base + longint'((l + (64'd1 << 14)) >> 15));
   endfunction

endpackage

// ----- rtl/core/logistic_log_likelihood_accumulator.sv -----
// channel | ports                                            | direction
// req     | req_valid/req_ready, label, feat_0..3, last_row  | in
// rsp     | rsp_valid/rsp_ready, total, row_count, saturated | out
// csr     | csr_valid/csr_ready, csr_index, csr_data         | in
//
// One multiplier is reused by a sequencer: four dot-product steps, each a
// multiply then an add state, the table position, then the interpolation.
// Rows with xb outside -8.0..+8.0 skip the table and interpolation, a row
// at exactly +8.0 skips the interpolation, and a last row adds a done state
// that waits to load the result register. Reset is synchronous and clears
// coefficients, sums and the result valid flag. A stalled result holds in
// its register and does not block the next row until that row is also last.
module logistic_log_likelihood_accumulator #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_label,
   input  logic signed [lll_pkg::FEAT_W-1:0]     req_feat_0,
   input  logic signed [lll_pkg::FEAT_W-1:0]     req_feat_1,
   input  logic signed [lll_pkg::FEAT_W-1:0]     req_feat_2,
   input  logic signed [lll_pkg::FEAT_W-1:0]     req_feat_3,
   input  logic                                  req_last_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lll_pkg::ACC_W-1:0]      rsp_total,
   output logic [lll_pkg::CNT_W-1:0]             rsp_row_count,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lll_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic signed [lll_pkg::FEAT_W-1:0]     csr_data
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES + 1);
   localparam int NF     = lll_pkg::N_FEATURES;
   localparam int FW     = lll_pkg::FEAT_W;
   localparam int XW     = lll_pkg::XB_W;
   localparam int MW     = lll_pkg::MUL_W;
   localparam int PW     = lll_pkg::PROD_W;
   localparam int AW     = lll_pkg::ACC_W;
   localparam int SW     = lll_pkg::SP_W;
   localparam int QW     = lll_pkg::FRAC_W;

   lll_pkg::state_type state_ff;
   lll_pkg::state_type state_in;

   logic signed [FW-1:0]             coef_ff [NF];
   logic signed [FW-1:0]             coef_in [NF];
   logic signed [FW-1:0]             feat_ff [NF];
   logic signed [FW-1:0]             feat_in [NF];
   logic                             label_ff;
   logic                             label_in;
   logic                             last_ff;
   logic                             last_in;
   logic [lll_pkg::FI_W-1:0]         cnt_ff;
   logic [lll_pkg::FI_W-1:0]         cnt_in;
   logic signed [lll_pkg::DOT_W-1:0] dot_ff;
   logic signed [lll_pkg::DOT_W-1:0] dot_in;
   logic [ADDR_W-1:0]                idx_ff;
   logic [ADDR_W-1:0]                idx_in;
   logic [QW-1:0]                    frac_ff;
   logic [QW-1:0]                    frac_in;
   logic [SW-1:0]                    t0_ff;
   logic [SW-1:0]                    t0_in;
   logic signed [XW-1:0]             sp_ff;
   logic signed [XW-1:0]             sp_in;
   logic signed [AW-1:0]             acc_ff;
   logic signed [AW-1:0]             acc_in;
   logic [lll_pkg::CNT_W-1:0]        rows_ff;
   logic [lll_pkg::CNT_W-1:0]        rows_in;
   logic                             sat_ff;
   logic                             sat_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic signed [AW-1:0]             rsp_ll_ff;
   logic signed [AW-1:0]             rsp_ll_in;
   logic [lll_pkg::CNT_W-1:0]        rsp_cnt_ff;
   logic [lll_pkg::CNT_W-1:0]        rsp_cnt_in;
   logic                             rsp_sat_ff;
   logic                             rsp_sat_in;

   logic signed [MW-1:0]             mul_a;
   logic signed [MW-1:0]             mul_b;
   logic signed [PW-1:0]             prod;
   logic [ADDR_W-1:0]                rom_addr;
   logic [SW-1:0]                    rom_data;

   logic signed [XW-1:0]             xb;
   logic signed [XW-1:0]             xb_pos;
   logic                             xb_low;
   logic                             xb_high;
   logic                             idx_top;
   logic                             out_free;
   logic signed [XW:0]               term_raw;
   logic signed [XW:0]               term;
   logic signed [AW:0]               sum_wide;
   logic                             underflow;

   lll_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   lll_sp_rom #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   assign xb       = dot_ff[lll_pkg::DOT_W-1:lll_pkg::XB_SHIFT];
   assign xb_pos   = xb + lll_pkg::XB_HI;
   assign xb_low   = xb < lll_pkg::XB_LO;
   assign xb_high  = xb > lll_pkg::XB_HI;
   assign idx_top  = idx_ff == ADDR_W'(TABLE_ENTRIES);
   assign out_free = !rsp_valid_ff || rsp_ready;

   function automatic logic signed [XW:0] req_label_term();
      logic signed [XW:0] sp_w;
      sp_w = (XW+1)'(sp_ff);
      if (label_ff) begin
         return (XW+1)'(xb) - sp_w;
      end
      return -sp_w;
   endfunction

   always_comb begin
      term_raw = req_label_term();
      term     = (term_raw > 0) ? '0 : term_raw;
      sum_wide = (AW+1)'(acc_ff) + (AW+1)'(term);
      underflow = sum_wide[AW] != sum_wide[AW-1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lll_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = lll_pkg::S_MUL;
            end
         end
         lll_pkg::S_MUL: begin
            state_in = lll_pkg::S_DOT;
         end
         lll_pkg::S_DOT: begin
            if (cnt_ff == lll_pkg::FI_W'(NF - 1)) begin
               state_in = lll_pkg::S_RANGE;
            end else begin
               state_in = lll_pkg::S_MUL;
            end
         end
         lll_pkg::S_RANGE: begin
            if (xb_low || xb_high) begin
               state_in = lll_pkg::S_TERM;
            end else begin
               state_in = lll_pkg::S_POS;
            end
         end
         lll_pkg::S_POS: begin
            state_in = lll_pkg::S_RD0;
         end
         lll_pkg::S_RD0: begin
            state_in = lll_pkg::S_RD1;
         end
         lll_pkg::S_RD1: begin
            state_in = lll_pkg::S_RD2;
         end
         lll_pkg::S_RD2: begin
            if (idx_top) begin
               state_in = lll_pkg::S_TERM;
            end else begin
               state_in = lll_pkg::S_INTERP;
            end
         end
         lll_pkg::S_INTERP: begin
            state_in = lll_pkg::S_TERM;
         end
         lll_pkg::S_TERM: begin
            if (last_ff) begin
               state_in = lll_pkg::S_DONE;
            end else begin
               state_in = lll_pkg::S_IDLE;
            end
         end
         lll_pkg::S_DONE: begin
            if (out_free) begin
               state_in = lll_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lll_pkg::S_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      rom_addr  = idx_ff;
      case (state_ff)
         lll_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         lll_pkg::S_MUL: begin
            mul_a = MW'(feat_ff[cnt_ff]);
            mul_b = MW'(coef_ff[cnt_ff]);
         end
         lll_pkg::S_RANGE: begin
            mul_a = xb_pos[MW-1:0];
            mul_b = MW'(TABLE_ENTRIES);
         end
         lll_pkg::S_RD1: begin
            rom_addr = idx_top ? idx_ff : ADDR_W'(idx_ff + 1'b1);
         end
         lll_pkg::S_RD2: begin
            mul_a = $signed(MW'(rom_data)) - $signed(MW'(t0_ff));
            mul_b = $signed(MW'(frac_ff));
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      coef_in      = coef_ff;
      feat_in      = feat_ff;
      label_in     = label_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      dot_in       = dot_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      t0_in        = t0_ff;
      sp_in        = sp_ff;
      acc_in       = acc_ff;
      rows_in      = rows_ff;
      sat_in       = sat_ff;
      rsp_ll_in    = rsp_ll_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid && csr_ready) begin
         for (int i = 0; i < NF; i++) begin
            if (csr_index == lll_pkg::CSR_IDX_W'(lll_pkg::COEF_BASE + i)) begin
               coef_in[i] = csr_data;
            end
         end
      end

      case (state_ff)
         lll_pkg::S_IDLE: begin
            feat_in[0] = req_feat_0;
            feat_in[1] = req_feat_1;
            feat_in[2] = req_feat_2;
            feat_in[3] = req_feat_3;
            label_in   = req_label;
            last_in    = req_last_row;
            cnt_in     = '0;
            dot_in     = '0;
         end
         lll_pkg::S_DOT: begin
            dot_in = dot_ff + lll_pkg::DOT_W'($signed(prod[lll_pkg::PAIR_W-1:0]));
            cnt_in = lll_pkg::FI_W'(cnt_ff + 1'b1);
         end
         lll_pkg::S_RANGE: begin
            sp_in = xb_high ? xb : '0;
         end
         lll_pkg::S_POS: begin
            idx_in  = prod[QW +: ADDR_W];
            frac_in = prod[QW-1:0];
         end
         lll_pkg::S_RD1: begin
            t0_in = rom_data;
         end
         lll_pkg::S_RD2: begin
            sp_in = XW'(t0_ff);
         end
         lll_pkg::S_INTERP: begin
            sp_in = XW'(t0_ff) + XW'($signed(prod[PW-1:QW]));
         end
         lll_pkg::S_TERM: begin
            if (underflow) begin
               acc_in = lll_pkg::ACC_MIN;
               sat_in = 1'b1;
            end else begin
               acc_in = sum_wide[AW-1:0];
            end
            if (rows_ff != '1) begin
               rows_in = rows_ff + 1'b1;
            end
         end
         lll_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ll_in    = acc_ff;
               rsp_cnt_in   = rows_ff;
               rsp_sat_in   = sat_ff;
               acc_in       = '0;
               rows_in      = '0;
               sat_in       = 1'b0;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lll_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         rows_ff      <= '0;
         sat_ff       <= 1'b0;
         for (int i = 0; i < NF; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         rows_ff      <= rows_in;
         sat_ff       <= sat_in;
         coef_ff      <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      feat_ff    <= feat_in;
      label_ff   <= label_in;
      last_ff    <= last_in;
      dot_ff     <= dot_in;
      idx_ff     <= idx_in;
      frac_ff    <= frac_in;
      t0_ff      <= t0_in;
      sp_ff      <= sp_in;
      rsp_ll_ff  <= rsp_ll_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_total     = rsp_ll_ff;
   assign rsp_row_count = rsp_cnt_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ----- rtl/core/lll_mul.sv -----
module lll_mul (
   input  logic                              clock,
   input  logic signed [lll_pkg::MUL_W-1:0]  op_a,
   input  logic signed [lll_pkg::MUL_W-1:0]  op_b,
   output logic signed [lll_pkg::PROD_W-1:0] prod
);

   logic signed [lll_pkg::PROD_W-1:0] prod_ff;
   logic signed [lll_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/lll_sp_rom.sv -----
module lll_sp_rom #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                                    clock,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0]      addr,
   output logic [lll_pkg::SP_W-1:0]                data
);

   localparam int TBL_BITS = (TABLE_ENTRIES + 1) * lll_pkg::SP_W;

   function automatic logic [TBL_BITS-1:0] build_table();
      logic [TBL_BITS-1:0] bits;
      int                  k;
      bits = '0;
      for (k = 0; k <= TABLE_ENTRIES; k++) begin
         bits[k*lll_pkg::SP_W +: lll_pkg::SP_W] = lll_pkg::sp_point(k, TABLE_ENTRIES);
      end
      return bits;
   endfunction

   localparam logic [TBL_BITS-1:0] TABLE_BITS = build_table();

   logic [lll_pkg::SP_W-1:0] data_ff;
   logic [lll_pkg::SP_W-1:0] data_in;

   always_comb begin
      data_in = TABLE_BITS[int'(addr)*lll_pkg::SP_W +: lll_pkg::SP_W];
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- rtl/core/lll_checker.sv -----
module lll_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [lll_pkg::ACC_W-1:0]  rsp_total,
   input logic [lll_pkg::CNT_W-1:0]         rsp_row_count,
   input logic                              rsp_saturated
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total)
         && $stable(rsp_row_count) && $stable(rsp_saturated))
      else $error("rsp payload changed while stalled");

   // a row keeps the block busy: req_ready is low in the cycle after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a transfer");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_count != '0)
      else $error("result with zero rows");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_total == lll_pkg::ACC_MIN)
      else $error("saturated total not at negative limit");

   a_nonpositive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total[lll_pkg::ACC_W-1] || rsp_total == '0)
      else $error("positive total");

endmodule

bind logistic_log_likelihood_accumulator lll_checker u_lll_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_total     (rsp_total),
   .rsp_row_count (rsp_row_count),
   .rsp_saturated (rsp_saturated)
);
